// ----- rtl/spiw_pkg.sv -----
`timescale 1ns / 1ps

package spiw_pkg;

	localparam int TIMER_BITS   = 22;
	localparam int HALF_BITS    = 16;
	localparam int DEF_WORD_BITS = 8;
	localparam int BYTE_BITS    = 8;
	localparam int REG_IDX_BITS = 3;

	localparam logic [HALF_BITS-1:0]  RST_HALF_PERIOD = HALF_BITS'(16);
	localparam logic [TIMER_BITS-1:0] RST_RESET_HOLD  = TIMER_BITS'(2000000);
	localparam logic [TIMER_BITS-1:0] RST_BOOT_WAIT   = TIMER_BITS'(10000);
	localparam logic [TIMER_BITS-1:0] RST_FIRST_IVL   = TIMER_BITS'(7000);
	localparam logic [TIMER_BITS-1:0] RST_STEP_IVL    = TIMER_BITS'(1000);
	localparam logic [TIMER_BITS-1:0] RST_LAST_IVL    = TIMER_BITS'(9000);

	localparam logic [REG_IDX_BITS-1:0] REG_HALF_PERIOD = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_RESET_HOLD  = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_BOOT_WAIT   = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_FIRST_IVL   = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_STEP_IVL    = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_LAST_IVL    = 3'd5;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_WAKE = 2'd1;
	localparam logic [1:0] CMD_XFER = 2'd2;

	typedef struct packed {
		logic [HALF_BITS-1:0]  half_period;
		logic [TIMER_BITS-1:0] reset_hold;
		logic [TIMER_BITS-1:0] boot_wait;
		logic [TIMER_BITS-1:0] first_ivl;
		logic [TIMER_BITS-1:0] step_ivl;
		logic [TIMER_BITS-1:0] last_ivl;
	} cfg_t;

	typedef struct packed {
		logic sclk;
		logic mosi;
		logic drv_en;
		logic drv_lvl;
		logic rst;
	} pins_t;

	typedef struct packed {
		pins_t                pins;
		logic                 busy;
		logic                 done;
		logic                 ok;
		logic [BYTE_BITS-1:0] rx_byte;
	} res_t;

endpackage

// ----- rtl/spiw_cfg.sv -----
`timescale 1ns / 1ps

module spiw_cfg import spiw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [REG_IDX_BITS-1:0] cfg_index,
	input  logic [TIMER_BITS-1:0]   cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= RST_HALF_PERIOD;
			cfg_q.reset_hold  <= RST_RESET_HOLD;
			cfg_q.boot_wait   <= RST_BOOT_WAIT;
			cfg_q.first_ivl   <= RST_FIRST_IVL;
			cfg_q.step_ivl    <= RST_STEP_IVL;
			cfg_q.last_ivl    <= RST_LAST_IVL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_PERIOD: cfg_q.half_period <= cfg_data[HALF_BITS-1:0];
				REG_RESET_HOLD:  cfg_q.reset_hold  <= cfg_data;
				REG_BOOT_WAIT:   cfg_q.boot_wait   <= cfg_data;
				REG_FIRST_IVL:   cfg_q.first_ivl   <= cfg_data;
				REG_STEP_IVL:    cfg_q.step_ivl    <= cfg_data;
				REG_LAST_IVL:    cfg_q.last_ivl    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/spiw_seq.sv -----
`timescale 1ns / 1ps

module spiw_seq import spiw_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [1:0]           cmd,
	input  logic [BYTE_BITS-1:0] tx_byte,
	input  logic                 miso_level,
	input  cfg_t                 cfg,
	output res_t                 res
);

	localparam int IDX_BITS = $clog2(WORD_BITS);

	typedef enum logic [12:0] {
		PH_IDLE       = 13'b0000000000001,
		PH_RESET_HOLD = 13'b0000000000010,
		PH_BOOT       = 13'b0000000000100,
		PH_LOW_A      = 13'b0000000001000,
		PH_LOW_B      = 13'b0000000010000,
		PH_MISO_HI    = 13'b0000000100000,
		PH_SCLK_HI    = 13'b0000001000000,
		PH_SCLK_LO    = 13'b0000010000000,
		PH_MISO_LO    = 13'b0000100000000,
		PH_RELEASE    = 13'b0001000000000,
		PH_WAIT_FALL  = 13'b0010000000000,
		PH_X_WAIT     = 13'b0100000000000,
		PH_X_LOW      = 13'b1000000000000
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] count_q, count_d, count_inc;
	logic [TIMER_BITS-1:0] ivl_q, ivl_d;
	logic [IDX_BITS-1:0]   bit_q, bit_d;
	logic [WORD_BITS-1:0]  send_q, send_d, recv_q, recv_d;
	logic [BYTE_BITS-1:0]  rx_q, rx_d;
	pins_t                 pins_q, pins_d;
	logic                  done, ok;

	logic [TIMER_BITS-1:0] half_len, hold_len, ivl_len, len;
	logic [TIMER_BITS:0]   ivl_sum;
	logic                  ivl_fits, first_fits, hit;

	assign count_inc  = count_q + TIMER_BITS'(1);
	assign half_len   = (cfg.half_period == '0) ? TIMER_BITS'(1)
		: TIMER_BITS'(cfg.half_period);
	assign hold_len   = (cfg.reset_hold == '0) ? TIMER_BITS'(1) : cfg.reset_hold;
	assign ivl_len    = (ivl_q == '0) ? TIMER_BITS'(1) : ivl_q;
	assign ivl_sum    = {1'b0, ivl_q} + {1'b0, cfg.step_ivl};
	assign ivl_fits   = ivl_sum <= {1'b0, cfg.last_ivl};
	assign first_fits = cfg.first_ivl <= cfg.last_ivl;

	always_comb begin
		if (phase_q == PH_RESET_HOLD) begin
			len = hold_len;
		end else if (phase_q == PH_BOOT) begin
			len = cfg.boot_wait;
		end else if (phase_q == PH_X_WAIT || phase_q == PH_X_LOW) begin
			len = half_len;
		end else begin
			len = ivl_len;
		end
	end

	assign hit = count_inc >= len;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		ivl_d   = ivl_q;
		bit_d   = bit_q;
		send_d  = send_q;
		recv_d  = recv_q;
		rx_d    = rx_q;
		pins_d  = pins_q;
		done    = 1'b0;
		ok      = 1'b0;
		if (phase_q == PH_IDLE) begin
			unique case (cmd)
				CMD_WAKE: begin
					pins_d.rst = 1'b0;
					phase_d    = PH_RESET_HOLD;
					count_d    = '0;
				end
				CMD_XFER: begin
					send_d  = WORD_BITS'(tx_byte);
					recv_d  = '0;
					bit_d   = IDX_BITS'(WORD_BITS - 1);
					phase_d = PH_X_WAIT;
					count_d = '0;
				end
				default: begin
				end
			endcase
		end else if (phase_q == PH_WAIT_FALL) begin
			if (!miso_level) begin
				pins_d.sclk    = 1'b0;
				pins_d.mosi    = 1'b0;
				pins_d.drv_en  = 1'b0;
				pins_d.drv_lvl = 1'b0;
				done           = 1'b1;
				ok             = 1'b1;
				phase_d        = PH_IDLE;
				count_d        = '0;
			end
		end else begin
			count_d = count_inc;
			if (hit) begin
				count_d = '0;
				unique case (phase_q) inside
					PH_RESET_HOLD, PH_BOOT: begin
						pins_d.rst = 1'b1;
						if (phase_q == PH_RESET_HOLD && cfg.boot_wait != '0) begin
							phase_d = PH_BOOT;
						end else if (first_fits) begin
							ivl_d          = cfg.first_ivl;
							pins_d.sclk    = 1'b0;
							pins_d.mosi    = 1'b0;
							pins_d.drv_en  = 1'b1;
							pins_d.drv_lvl = 1'b0;
							phase_d        = PH_LOW_A;
						end else begin
							ivl_d          = cfg.first_ivl;
							pins_d.sclk    = 1'b0;
							pins_d.mosi    = 1'b0;
							pins_d.drv_en  = 1'b0;
							pins_d.drv_lvl = 1'b0;
							done           = 1'b1;
							phase_d        = PH_IDLE;
						end
					end
					PH_LOW_A: phase_d = PH_LOW_B;
					PH_LOW_B: begin
						pins_d.drv_lvl = 1'b1;
						phase_d        = PH_MISO_HI;
					end
					PH_MISO_HI: begin
						pins_d.sclk = 1'b1;
						phase_d     = PH_SCLK_HI;
					end
					PH_SCLK_HI: begin
						pins_d.sclk = 1'b0;
						phase_d     = PH_SCLK_LO;
					end
					PH_SCLK_LO: begin
						pins_d.drv_lvl = 1'b0;
						phase_d        = PH_MISO_LO;
					end
					PH_MISO_LO: begin
						pins_d.drv_en = 1'b0;
						phase_d       = PH_RELEASE;
					end
					PH_RELEASE: begin
						pins_d.sclk    = 1'b0;
						pins_d.mosi    = 1'b0;
						pins_d.drv_lvl = 1'b0;
						if (miso_level) begin
							pins_d.drv_en = 1'b0;
							phase_d       = PH_WAIT_FALL;
						end else if (ivl_fits) begin
							ivl_d         = ivl_sum[TIMER_BITS-1:0];
							pins_d.drv_en = 1'b1;
							phase_d       = PH_LOW_A;
						end else begin
							pins_d.drv_en = 1'b0;
							done          = 1'b1;
							phase_d       = PH_IDLE;
						end
					end
					PH_X_WAIT: begin
						pins_d.sclk = 1'b0;
						pins_d.mosi = send_q[bit_q];
						phase_d     = PH_X_LOW;
					end
					PH_X_LOW: begin
						pins_d.sclk   = 1'b1;
						recv_d[bit_q] = recv_q[bit_q] | miso_level;
						if (bit_q == '0) begin
							rx_d    = recv_d[BYTE_BITS-1:0];
							done    = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							bit_d   = bit_q - IDX_BITS'(1);
							phase_d = PH_X_WAIT;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			ivl_q   <= '0;
			bit_q   <= IDX_BITS'(WORD_BITS - 1);
			send_q  <= '0;
			recv_q  <= '0;
			rx_q    <= '0;
			pins_q  <= '{sclk: 1'b0, mosi: 1'b0, drv_en: 1'b0, drv_lvl: 1'b0, rst: 1'b1};
		end else if (step_en) begin
			phase_q <= phase_d;
			count_q <= count_d;
			ivl_q   <= ivl_d;
			bit_q   <= bit_d;
			send_q  <= send_d;
			recv_q  <= recv_d;
			rx_q    <= rx_d;
			pins_q  <= pins_d;
		end
	end

	assign res.pins    = pins_d;
	assign res.busy    = phase_d != PH_IDLE;
	assign res.done    = done;
	assign res.ok      = ok;
	assign res.rx_byte = rx_d;

	// The partner is held in reset only during the hold phase.
	a_rst_only_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_RESET_HOLD |-> pins_q.rst)
		else $error("reset line low outside the hold phase");

	// A completed operation always leaves the sequencer idle.
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && done |=> phase_q == PH_IDLE)
		else $error("sequencer not idle after completion");

	// Nothing advances without an accepted tick.
	a_hold_without_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(phase_q) && $stable(count_q) && $stable(pins_q))
		else $error("state changed without an accepted tick");

endmodule

// ----- rtl/spi_link_with_wake_handshake_top.sv -----
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    cmd, tx_byte, miso_level
// output    out_valid / out_ready  sclk_level .. rx_byte (one result per tick)
// config    cfg_we                 cfg_index, cfg_data
//
// A tick is accepted every cycle while results drain.
// The sequencer state and the result register update on the same accepted edge.
// The result register accepts a new tick whenever it is empty or being read.
// An asynchronous reset clears the sequencer, loads the default timings and
// empties the result register.

module spi_link_with_wake_handshake_top import spiw_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [REG_IDX_BITS-1:0] cfg_index,
	input  logic [TIMER_BITS-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              cmd,
	input  logic [BYTE_BITS-1:0]    tx_byte,
	input  logic                    miso_level,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    sclk_level,
	output logic                    mosi_level,
	output logic                    miso_drive_enable,
	output logic                    miso_drive_level,
	output logic                    reset_level,
	output logic                    busy_res,
	output logic                    done_res,
	output logic                    wake_ok,
	output logic [BYTE_BITS-1:0]    rx_byte
);

	cfg_t cfg;
	res_t res;
	res_t result_q;
	logic out_valid_q;
	logic step_en;

	assign in_ready = !out_valid_q || out_ready;
	assign step_en  = in_valid && in_ready;

	spiw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spiw_seq #(
		.WORD_BITS (WORD_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.cmd        (cmd),
		.tx_byte    (tx_byte),
		.miso_level (miso_level),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign sclk_level        = result_q.pins.sclk;
	assign mosi_level        = result_q.pins.mosi;
	assign miso_drive_enable = result_q.pins.drv_en;
	assign miso_drive_level  = result_q.pins.drv_lvl;
	assign reset_level       = result_q.pins.rst;
	assign busy_res          = result_q.busy;
	assign done_res          = result_q.done;
	assign wake_ok           = result_q.ok;
	assign rx_byte           = result_q.rx_byte;

	// Every accepted tick produces a result on the next cycle.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> out_valid_q)
		else $error("accepted tick produced no result");

	// A result reporting completion never claims the sequencer is still busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.done |-> !result_q.busy)
		else $error("completion reported while busy");

endmodule
